### src/dnsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsc_pkg
// Types and constants shared by the domain name syntax checker modules.
// ----------------------------------------------------------------------------
package dnsc_pkg;

  localparam int unsigned NameLenW  = 9;
  localparam int unsigned LabelLenW = 7;
  localparam int unsigned PrefixW   = 3;

  localparam logic [NameLenW-1:0]  NAME_MAX_LEN  = 9'd255;
  localparam logic [NameLenW-1:0]  NAME_LEN_SAT  = 9'd511;
  localparam logic [LabelLenW-1:0] LABEL_MAX_LEN = 7'd63;
  localparam logic [LabelLenW-1:0] LABEL_LEN_SAT = 7'd127;

  localparam logic [PrefixW-1:0] PREFIX_NONE   = 3'd0;
  localparam logic [PrefixW-1:0] PREFIX_FULL   = 3'd4;
  localparam logic [PrefixW-1:0] PREFIX_FAILED = 3'd5;

  localparam logic [7:0] CHAR_DOT        = 8'h2E;
  localparam logic [7:0] CHAR_HYPHEN     = 8'h2D;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_X          = 8'h78;
  localparam logic [7:0] CHAR_N          = 8'h6E;

  typedef struct packed {
    logic [NameLenW-1:0]  name_length;
    logic [LabelLenW-1:0] label_length;
    logic                 label_has_digit;
    logic                 label_has_hyphen;
    logic                 label_has_underscore;
    logic [PrefixW-1:0]   prefix_match_state;
    logic                 name_rejected;
  } dnsc_state_t;

  localparam dnsc_state_t STATE_RESET = '{
    name_length:          '0,
    label_length:         '0,
    label_has_digit:      1'b0,
    label_has_hyphen:     1'b0,
    label_has_underscore: 1'b0,
    prefix_match_state:   PREFIX_NONE,
    name_rejected:        1'b0
  };

  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CHAR_X;
      2'd1:    c = CHAR_N;
      default: c = CHAR_HYPHEN;
    endcase
    return c;
  endfunction

endpackage

### src/dnsc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsc_step
// Per-byte next-state and verdict logic of the domain name syntax checker.
// ----------------------------------------------------------------------------
module dnsc_step (
  input  dnsc_pkg::dnsc_state_t state_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output dnsc_pkg::dnsc_state_t state_o,
  output logic                  ok_o
);
  import dnsc_pkg::*;

  dnsc_state_t upd;
  logic [NameLenW-1:0] nl;
  logic is_dot, alpha, digit, hyphen, under;
  logic label_len_bad, final_ok;

  always_comb begin
    nl = (state_i.name_length < NAME_LEN_SAT) ? state_i.name_length + 9'd1
                                              : state_i.name_length;
    is_dot = (byte_i == CHAR_DOT);
    alpha  = (byte_i >= 8'h41 && byte_i <= 8'h5A) || (byte_i >= 8'h61 && byte_i <= 8'h7A);
    digit  = (byte_i >= 8'h30 && byte_i <= 8'h39);
    hyphen = (byte_i == CHAR_HYPHEN);
    under  = (byte_i == CHAR_UNDERSCORE);

    upd = state_i;
    upd.name_length = nl;
    if (!is_dot) begin
      if (!(alpha || digit || hyphen || under)) begin
        upd.name_rejected = 1'b1;
      end
      upd.label_has_digit      = state_i.label_has_digit | digit;
      upd.label_has_hyphen     = state_i.label_has_hyphen | hyphen;
      upd.label_has_underscore = state_i.label_has_underscore | under;
      if (state_i.prefix_match_state < PREFIX_FULL) begin
        if (byte_i == prefix_char(state_i.prefix_match_state[1:0])) begin
          upd.prefix_match_state = state_i.prefix_match_state + 3'd1;
        end else begin
          upd.prefix_match_state = PREFIX_FAILED;
        end
      end
      if (state_i.label_length < LABEL_LEN_SAT) begin
        upd.label_length = state_i.label_length + 7'd1;
      end
    end

    label_len_bad = (upd.label_length == '0) || (upd.label_length > LABEL_MAX_LEN);
    final_ok = !(nl > NAME_MAX_LEN) && !label_len_bad &&
               ((upd.prefix_match_state == PREFIX_FULL) ||
                (!upd.label_has_digit && !(upd.label_has_hyphen && upd.label_has_underscore)));

    if (is_dot && last_i && nl == 9'd1) begin
      ok_o = 1'b1;
    end else begin
      ok_o = !upd.name_rejected && final_ok;
    end

    if (last_i) begin
      state_o = STATE_RESET;
    end else if (is_dot) begin
      state_o = STATE_RESET;
      state_o.name_length   = nl;
      state_o.name_rejected = state_i.name_rejected | label_len_bad;
    end else begin
      state_o = upd;
    end
  end

endmodule

### src/domain_name_syntax_checker_top.sv
`timescale 1ns / 1ps
// The verdict is registered and appears on the output in the cycle after the
// byte that ends a name is transferred.
// Throughput: one byte per cycle while the verdict is not stalled; the per-byte
// counter and flag update is a single combinational step into the state registers.
// Reset: synchronous, active low; clears the name state and out_tvalid, not the verdict bit.
// ----------------------------------------------------------------------------
// domain_name_syntax_checker_top
// Checks the syntax of a domain name streamed one byte per transfer and
// returns one valid or invalid verdict per name.
// ----------------------------------------------------------------------------
module domain_name_syntax_checker_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] name_byte
  input  logic       in_tlast,   // end_of_name
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] name_valid, [7:1] zero
);
  import dnsc_pkg::*;

  dnsc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        valid_bit_r, valid_bit_nxt;
  logic        step_ok;
  logic        in_xfer;

  dnsc_step u_step (
    .state_i (state_r),
    .byte_i  (in_tdata),
    .last_i  (in_tlast),
    .state_o (state_nxt),
    .ok_o    (step_ok)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    valid_bit_nxt = valid_bit_r;
    if (in_xfer && in_tlast) begin
      out_valid_nxt = 1'b1;
      valid_bit_nxt = step_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    valid_bit_r <= valid_bit_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, valid_bit_r};

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tlast |=> state_r.name_length == '0 && out_tvalid)
    else $error("state not cleared after end of name");
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while verdict stalled");
  a_label_within_name: assert property (@(posedge clk) disable iff (!rst_n)
    {2'b00, state_r.label_length} <= state_r.name_length)
    else $error("label longer than name");
  a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.prefix_match_state <= PREFIX_FAILED)
    else $error("prefix tracker out of range");
`endif

endmodule
